FILE: design/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types, codes and reset values for the hybrid logical clock.
// ----------------------------------------------------------------------------
package hlc_pkg;

    // Default widths of the physical and logical parts of a timestamp
    localparam int PHYS_BITS_DEF    = 48;
    localparam int LOGICAL_BITS_DEF = 16;

    // Configuration registers
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 4;
    localparam int ORIGIN_BITS   = 32;

    localparam logic [CFG_DATA_BITS-1:0] NODE_ORIGIN_RST  = 32'd0;
    localparam logic [CFG_DATA_BITS-1:0] BORROW_LIMIT_RST = 32'd1000;
    localparam logic [CFG_DATA_BITS-1:0] SKEW_LIMIT_RST   = 32'd60000;

    typedef enum logic [1:0] {
        REG_NODE_ORIGIN  = 2'd0,
        REG_BORROW_LIMIT = 2'd1,
        REG_SKEW_LIMIT   = 2'd2
    } t_reg_idx;

    typedef enum logic {
        MODE_LOCAL   = 1'b0,
        MODE_RECEIVE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BACKPRESSURE = 2'd1,
        ST_SKEW_REJECT  = 2'd2
    } t_status;

    // Register values seen by the datapath
    typedef struct packed {
        logic [ORIGIN_BITS-1:0]   node_origin;
        logic [CFG_DATA_BITS-1:0] borrow_limit_ms;
        logic [CFG_DATA_BITS-1:0] skew_limit_ms;
    } t_cfg;

endpackage

FILE: design/hlc_cfg.sv
// ----------------------------------------------------------------------------
// hlc_cfg
// Configuration register file behind a simple peripheral bus port.
// ----------------------------------------------------------------------------
module hlc_cfg
    import hlc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [CFG_DATA_BITS-1:0] i_pwdata,
    output logic [CFG_DATA_BITS-1:0] o_prdata,
    output t_cfg                     o_cfg
);

    logic                     w_wr;
    logic [1:0]               w_idx;
    logic [ORIGIN_BITS-1:0]   r_node_origin;
    logic [CFG_DATA_BITS-1:0] r_borrow_limit;
    logic [CFG_DATA_BITS-1:0] r_skew_limit;

    // Write strobe on the access phase; the port never waits
    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = i_paddr[CFG_ADDR_BITS-1:2];

    // Write the addressed register; drop writes past the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_origin  <= NODE_ORIGIN_RST;
            r_borrow_limit <= BORROW_LIMIT_RST;
            r_skew_limit   <= SKEW_LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_NODE_ORIGIN:  r_node_origin  <= i_pwdata;
                REG_BORROW_LIMIT: r_borrow_limit <= i_pwdata;
                REG_SKEW_LIMIT:   r_skew_limit   <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_NODE_ORIGIN:  o_prdata = r_node_origin;
            REG_BORROW_LIMIT: o_prdata = r_borrow_limit;
            REG_SKEW_LIMIT:   o_prdata = r_skew_limit;
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg.node_origin     = r_node_origin;
    assign o_cfg.borrow_limit_ms = r_borrow_limit;
    assign o_cfg.skew_limit_ms   = r_skew_limit;

endmodule

FILE: design/hybrid_logical_clock.sv
// ----------------------------------------------------------------------------
// hybrid_logical_clock
// Hybrid logical clock: local events and remote merges, one per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one event per clock and returns one timestamp per event:
// the event is held in the input register, then the update step writes the clock
// state and the result register together. The clock state is read and written
// in that single update step, so back-to-back events see each other's effect
// with no gap; the rate is one transfer per clock for as long as the result
// side takes them. Registers are meant to be written only while no event is in
// flight.
module hybrid_logical_clock
    import hlc_pkg::*;
#(
    parameter  int PHYS_BITS    = PHYS_BITS_DEF,
    parameter  int LOGICAL_BITS = LOGICAL_BITS_DEF,
    localparam int IN_BITS      = ((2*PHYS_BITS + LOGICAL_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = ((PHYS_BITS + LOGICAL_BITS + ORIGIN_BITS + 7) / 8) * 8
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input event stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // phys_now_ms, remote_physical, remote_logical
    input  logic [IN_BITS-1:0]       s_axis_tdata,
    // mode
    input  logic                     s_axis_tuser,
    // timestamp stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // stamp_physical, stamp_logical, stamp_origin
    output logic [OUT_BITS-1:0]      m_axis_tdata,
    // status
    output logic [1:0]               m_axis_tuser,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam logic [PHYS_BITS-1:0]    PHYS_MAX = '1;
    localparam logic [LOGICAL_BITS-1:0] LOG_MAX  = '1;

    t_cfg w_cfg;

    logic w_in_take;
    logic w_move;

    // input register
    logic                    r_in_vld;
    t_mode                   r_in_mode;
    logic [PHYS_BITS-1:0]    r_in_pt;
    logic [PHYS_BITS-1:0]    r_in_rpt;
    logic [LOGICAL_BITS-1:0] r_in_rlog;

    // clock state
    logic [PHYS_BITS-1:0]    r_phys;
    logic [LOGICAL_BITS-1:0] r_logical;
    logic [PHYS_BITS-1:0]    n_phys;
    logic [LOGICAL_BITS-1:0] n_logical;
    t_status                 n_status;

    // result register
    logic                    r_out_vld;
    t_status                 r_out_status;
    logic [PHYS_BITS-1:0]    r_out_phys;
    logic [LOGICAL_BITS-1:0] r_out_log;
    logic [ORIGIN_BITS-1:0]  r_out_origin;

    // update step terms
    logic [PHYS_BITS:0]      w_pt_borrow;
    logic [PHYS_BITS:0]      w_pt_skew;
    logic [PHYS_BITS-1:0]    w_top;
    logic                    w_top_last;
    logic                    w_top_rem;
    logic [LOGICAL_BITS:0]   w_next;
    logic [LOGICAL_BITS-1:0] w_log_hi;
    logic [PHYS_BITS-1:0]    w_carry_base;
    logic [PHYS_BITS-1:0]    w_carry_phys;
    logic [LOGICAL_BITS-1:0] w_carry_log;

    hlc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    assign pready = 1'b1;

    // Handshake: the event advances when the result slot is free or drains
    assign w_move        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_move;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Hold the accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode <= t_mode'(s_axis_tuser);
            r_in_pt   <= s_axis_tdata[PHYS_BITS-1:0];
            r_in_rpt  <= s_axis_tdata[2*PHYS_BITS-1:PHYS_BITS];
            r_in_rlog <= s_axis_tdata[2*PHYS_BITS+LOGICAL_BITS-1:2*PHYS_BITS];
        end
    end

    // Limits added to physical time, one bit wider so nothing wraps
    assign w_pt_borrow = {1'b0, r_in_pt} + (PHYS_BITS+1)'(w_cfg.borrow_limit_ms);
    assign w_pt_skew   = {1'b0, r_in_pt} + (PHYS_BITS+1)'(w_cfg.skew_limit_ms);

    // Three-way maximum for a merge
    always_comb begin
        w_top = (r_phys > r_in_pt) ? r_phys : r_in_pt;
        if (r_in_rpt > w_top) begin
            w_top = r_in_rpt;
        end
    end

    assign w_top_last = (w_top == r_phys);
    assign w_top_rem  = (w_top == r_in_rpt);
    assign w_log_hi   = (r_logical > r_in_rlog) ? r_logical : r_in_rlog;

    // Logical part after a merge, with a spare bit to flag overflow
    always_comb begin
        if (w_top_last && w_top_rem) begin
            w_next = {1'b0, w_log_hi} + 1'b1;
        end else if (w_top_last) begin
            w_next = {1'b0, r_logical} + 1'b1;
        end else if (w_top_rem) begin
            w_next = {1'b0, r_in_rlog} + 1'b1;
        end else begin
            w_next = '0;
        end
    end

    // Carry into the next millisecond, pinned at the physical ceiling
    assign w_carry_base = (r_in_mode == MODE_LOCAL) ? r_phys : w_top;

    always_comb begin
        if (w_carry_base == PHYS_MAX) begin
            w_carry_phys = PHYS_MAX;
            w_carry_log  = LOG_MAX;
        end else begin
            w_carry_phys = w_carry_base + 1'b1;
            w_carry_log  = '0;
        end
    end

    // Next clock state and status for the event in the input register
    always_comb begin
        n_phys    = r_phys;
        n_logical = r_logical;
        n_status  = ST_OK;
        case (r_in_mode)
            MODE_LOCAL: begin
                if (r_in_pt > r_phys) begin
                    n_phys    = r_in_pt;
                    n_logical = '0;
                end else if (r_logical != LOG_MAX) begin
                    n_logical = r_logical + 1'b1;
                end else begin
                    n_phys    = w_carry_phys;
                    n_logical = w_carry_log;
                    if ((w_cfg.borrow_limit_ms != '0)
                            && ({1'b0, w_carry_phys} > w_pt_borrow)) begin
                        n_status = ST_BACKPRESSURE;
                    end
                end
            end
            MODE_RECEIVE: begin
                if ((w_cfg.skew_limit_ms != '0) && ({1'b0, r_in_rpt} > w_pt_skew)) begin
                    n_status = ST_SKEW_REJECT;
                end else if (!w_next[LOGICAL_BITS]) begin
                    n_phys    = w_top;
                    n_logical = w_next[LOGICAL_BITS-1:0];
                end else begin
                    n_phys    = w_carry_phys;
                    n_logical = w_carry_log;
                end
            end
            default: ;
        endcase
    end

    // Advance the clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys    <= '0;
            r_logical <= '0;
        end else if (w_move) begin
            r_phys    <= n_phys;
            r_logical <= n_logical;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_status <= n_status;
            r_out_phys   <= n_phys;
            r_out_log    <= n_logical;
            r_out_origin <= w_cfg.node_origin;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_BITS'({r_out_origin, r_out_log, r_out_phys});

`ifndef SYNTH
    // The clock never moves backward
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> {r_phys, r_logical} >= $past({r_phys, r_logical}))
        else $error("clock state moved backward");

    // A rejected remote timestamp leaves the clock untouched
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_status == ST_SKEW_REJECT) |=> $stable({r_phys, r_logical}))
        else $error("skew rejection changed clock state");

    // Backpressure only follows a borrow, which leaves logical zero or pinned
    a_borrow_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_status == ST_BACKPRESSURE)
            |=> (r_logical == '0 || r_logical == LOG_MAX))
        else $error("backpressure without a borrow");

    // A held event is not lost while the result side stalls
    a_hold_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_move) |=> r_in_vld)
        else $error("pending event dropped");
`endif

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hybrid logical clock. A scripted opening walks
// reset behavior, merges, carries, skew rejection and backpressure; random
// phases under changing register settings follow; a closing script drives
// the clock into its physical ceiling. Every timestamp is checked field by
// field against an in-bench model of the clock or a typed-in expectation,
// with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    import hlc_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int IN_BITS         = 112;
    localparam int OUT_BITS        = 96;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 190;
    localparam int SETTLE_CYCLES   = 4;

    localparam logic [47:0] PHYS_MAX = '1;
    localparam logic [15:0] LOG_MAX  = '1;
    localparam logic [CFG_ADDR_BITS-1:0] UNMAPPED_ADDR = 4'd12;

    // one timestamp as it leaves the block
    typedef struct packed {
        t_status     status;
        logic [47:0] phys;
        logic [15:0] logical;
        logic [31:0] origin;
    } t_stamp;

    // one scripted event, with an optional typed-in expectation
    typedef struct packed {
        t_mode       mode;
        logic [47:0] now_ms;
        logic [47:0] rem_ms;
        logic [15:0] rem_logical;
        logic        typed;
        t_status     st;
        logic [47:0] exp_ms;
        logic [15:0] exp_logical;
    } t_event_row;

    localparam int OPENING_ROWS = 19;
    localparam int SCRIPT_ROWS  = 24;

    localparam t_event_row SCRIPT [0:SCRIPT_ROWS-1] = '{
        // zero physical time just counts the logical part
        '{MODE_LOCAL,   48'd0,      48'd0,      16'd0,      1'b1, ST_OK, 48'd0, 16'd1},
        // remote fields are ignored on a local event
        '{MODE_LOCAL,   48'd100,    PHYS_MAX,   16'hFFFF,   1'b1, ST_OK, 48'd100, 16'd0},
        '{MODE_LOCAL,   48'd50,     48'd0,      16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd100,    48'd100,    16'd5,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd200,    48'd150,    16'd9,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd200,    48'd300,    16'd7,      1'b0, ST_OK, 48'd0, 16'd0},
        // one past the skew limit is rejected, clock held
        '{MODE_RECEIVE, 48'd0,      48'd60001,  16'h1234,   1'b1, ST_SKEW_REJECT,
          48'd300, 16'd8},
        // exactly at the skew limit, logical overflow carries
        '{MODE_RECEIVE, 48'd0,      48'd60000,  16'hFFFF,   1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd1,      48'd60001,  16'hFFFE,   1'b0, ST_OK, 48'd0, 16'd0},
        // saturated local count borrows a millisecond, small lead
        '{MODE_LOCAL,   48'd60001,  48'd0,      16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd60000,  48'd70000,  16'hFFFE,   1'b0, ST_OK, 48'd0, 16'd0},
        // borrow far ahead of physical time warns
        '{MODE_LOCAL,   48'd0,      48'd0,      16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd70001,  48'd70001,  16'hFFFF,   1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_LOCAL,   48'd70003,  48'd0,      16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_LOCAL,   48'd70003,  48'd0,      16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd70003,  48'd70003,  16'd0,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd80000,  48'd10,     16'hFFFF,   1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd80000,  48'd140000, 16'd3,      1'b0, ST_OK, 48'd0, 16'd0},
        '{MODE_RECEIVE, 48'd80000,  48'd140001, 16'd3,      1'b1, ST_SKEW_REJECT,
          48'd140000, 16'd4},
        // physical ceiling: clock pins at its maximum and never moves back
        '{MODE_RECEIVE, PHYS_MAX,   PHYS_MAX,   16'hFFFF,   1'b1, ST_OK, PHYS_MAX, LOG_MAX},
        '{MODE_LOCAL,   PHYS_MAX,   48'd0,      16'd0,      1'b1, ST_OK, PHYS_MAX, LOG_MAX},
        '{MODE_LOCAL,   48'd0,      48'd0,      16'd0,      1'b1, ST_BACKPRESSURE,
          PHYS_MAX, LOG_MAX},
        '{MODE_RECEIVE, 48'd0,      48'd0,      16'd0,      1'b1, ST_OK, PHYS_MAX, LOG_MAX},
        '{MODE_RECEIVE, 48'd0,      PHYS_MAX,   16'd0,      1'b1, ST_SKEW_REJECT,
          PHYS_MAX, LOG_MAX}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_BITS-1:0]       s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]      m_axis_tdata;
    logic [1:0]               m_axis_tuser;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // model of the clock state and the register file
    logic [47:0]              hlc_phys = '0;
    logic [15:0]              hlc_logical = '0;
    logic [CFG_DATA_BITS-1:0] cfg_regs [0:2];

    t_stamp      pending_stamps [$];
    int unsigned mismatch_count = 0;
    logic        steady_flow = 1'b0;
    int unsigned hold_cycles = 0;

    hybrid_logical_clock u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // add a signed offset to a physical time, clamped to the field range
    function automatic logic [47:0] sat_add(input logic [47:0] base, input longint delta);
        longint sum;
        sum = longint'({16'd0, base}) + delta;
        if (sum < 0) return '0;
        if (sum > longint'({16'd0, PHYS_MAX})) return PHYS_MAX;
        return sum[47:0];
    endfunction

    // step one millisecond ahead with logical zero, pinned at the ceiling
    task automatic carry_ms(input logic [47:0] base);
        if (base == PHYS_MAX) begin
            hlc_phys    = PHYS_MAX;
            hlc_logical = LOG_MAX;
        end else begin
            hlc_phys    = base + 48'd1;
            hlc_logical = '0;
        end
    endtask

    // advance the clock model by one event and form the timestamp
    task automatic advance_hlc(input t_mode mode, input logic [47:0] now_ms,
                               input logic [47:0] rem_ms, input logic [15:0] rem_logical,
                               output t_stamp stamp);
        t_status     st;
        logic [47:0] lead;
        logic [47:0] top;
        logic [48:0] reach;
        logic [16:0] next;
        st = ST_OK;
        if (mode == MODE_LOCAL) begin
            if (now_ms > hlc_phys) begin
                hlc_phys    = now_ms;
                hlc_logical = '0;
            end else if (hlc_logical != LOG_MAX) begin
                hlc_logical = hlc_logical + 16'd1;
            end else begin
                carry_ms(hlc_phys);
                lead = (hlc_phys > now_ms) ? hlc_phys - now_ms : '0;
                if (cfg_regs[REG_BORROW_LIMIT] != 0 &&
                    lead > {16'd0, cfg_regs[REG_BORROW_LIMIT]})
                    st = ST_BACKPRESSURE;
            end
        end else begin
            reach = {1'b0, now_ms} + {17'd0, cfg_regs[REG_SKEW_LIMIT]};
            if (cfg_regs[REG_SKEW_LIMIT] != 0 && {1'b0, rem_ms} > reach) begin
                st = ST_SKEW_REJECT;
            end else begin
                top = now_ms;
                if (hlc_phys > top) top = hlc_phys;
                if (rem_ms > top) top = rem_ms;
                if (top == hlc_phys && top == rem_ms)
                    next = ((hlc_logical > rem_logical) ? {1'b0, hlc_logical}
                                                        : {1'b0, rem_logical}) + 17'd1;
                else if (top == hlc_phys)
                    next = {1'b0, hlc_logical} + 17'd1;
                else if (top == rem_ms)
                    next = {1'b0, rem_logical} + 17'd1;
                else
                    next = '0;
                if (!next[16]) begin
                    hlc_phys    = top;
                    hlc_logical = next[15:0];
                end else begin
                    carry_ms(top);
                end
            end
        end
        stamp = '{status: st, phys: hlc_phys, logical: hlc_logical,
                  origin: cfg_regs[REG_NODE_ORIGIN]};
    endtask

    // offer one event, wait for its transfer, record the expected timestamp
    task automatic send_event(input t_mode mode, input logic [47:0] now_ms,
                              input logic [47:0] rem_ms, input logic [15:0] rem_logical,
                              input logic typed, input t_stamp typed_stamp);
        t_stamp      predicted;
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {rem_logical, rem_ms, now_ms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_hlc(mode, now_ms, rem_ms, rem_logical, predicted);
        pending_stamps.push_back(typed ? typed_stamp : predicted);
        gap = steady_flow ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random event near the current clock, with some full-range noise
    task automatic send_random();
        t_mode       mode;
        logic [47:0] now_ms;
        logic [47:0] rem_ms;
        logic [15:0] rem_logical;
        mode        = t_mode'($urandom_range(0, 1));
        rem_logical = 16'($urandom);
        if ($urandom_range(0, 2) == 0)
            rem_logical = LOG_MAX - 16'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 6) begin
            now_ms = 48'({$urandom, $urandom});
            rem_ms = 48'({$urandom, $urandom});
        end else begin
            case ($urandom_range(0, 3))
                0: now_ms = sat_add(hlc_phys, longint'($urandom_range(0, 3)));
                1: now_ms = sat_add(hlc_phys, -longint'($urandom_range(0, 2000)));
                // straddle the borrow limit after a carry
                2: now_ms = sat_add(hlc_phys, longint'($urandom_range(0, 2)) -
                                              longint'(cfg_regs[REG_BORROW_LIMIT]));
                default: now_ms = sat_add(hlc_phys, longint'($urandom_range(1, 5000)));
            endcase
            case ($urandom_range(0, 3))
                0: rem_ms = sat_add(hlc_phys, longint'($urandom_range(0, 6)) - 3);
                // straddle the skew limit
                1: rem_ms = sat_add(now_ms, longint'(cfg_regs[REG_SKEW_LIMIT]) +
                                            longint'($urandom_range(0, 2)) - 1);
                2: rem_ms = sat_add(now_ms, -longint'($urandom_range(0, 100)));
                default: rem_ms = sat_add(hlc_phys, longint'($urandom_range(0, 200)));
            endcase
        end
        send_event(mode, now_ms, rem_ms, rem_logical, 1'b0, '0);
    endtask

    // read one register back and compare with the model
    task automatic check_reg(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== cfg_regs[idx])
            flag_mismatch($sformatf("register %s readback", idx.name()), 64'(prdata),
                          64'(cfg_regs[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write one register through setup and access, then read it back (all registers after an unmapped write)
    task automatic program_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                               input logic [CFG_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr[3:2] <= REG_SKEW_LIMIT) begin
            cfg_regs[addr[3:2]] = value;
            check_reg(t_reg_idx'(addr[3:2]));
        end else begin
            // unmapped write must leave every register untouched
            check_reg(REG_NODE_ORIGIN);
            check_reg(REG_BORROW_LIMIT);
            check_reg(REG_SKEW_LIMIT);
        end
    endtask

    // drop valid and hold until every timestamp has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_stamps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stall the timestamp side at random, except in steady stretches
    always @(posedge i_clk) begin : ready_pattern
        int unsigned stall;
        if (steady_flow) begin
            m_axis_tready <= 1'b1;
            hold_cycles   <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (m_axis_tready) begin
            stall = idle_len();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles   <= stall - 1;
            end
        end else begin
            m_axis_tready <= 1'b1;
            hold_cycles   <= $urandom_range(0, 12);
        end
    end

    // compare each timestamp transfer with the oldest expectation
    always @(posedge i_clk) begin : stamp_monitor
        t_stamp got;
        t_stamp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{status: t_status'(m_axis_tuser), phys: m_axis_tdata[47:0],
                    logical: m_axis_tdata[63:48], origin: m_axis_tdata[95:64]};
            if (pending_stamps.size() == 0) begin
                flag_mismatch("timestamp with nothing pending, physical", 64'(got.phys), '0);
            end else begin
                want = pending_stamps.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.phys !== want.phys)
                    flag_mismatch("stamp_physical", 64'(got.phys), 64'(want.phys));
                if (got.logical !== want.logical)
                    flag_mismatch("stamp_logical", 64'(got.logical), 64'(want.logical));
                if (got.origin !== want.origin)
                    flag_mismatch("stamp_origin", 64'(got.origin), 64'(want.origin));
            end
        end
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("[hybrid_logical_clock] ERROR");
        $finish;
    end

    initial begin : stimulus
        t_stamp                   typed_stamp;
        logic [CFG_DATA_BITS-1:0] origin;
        logic [CFG_DATA_BITS-1:0] borrow;
        logic [CFG_DATA_BITS-1:0] skew;
        cfg_regs[REG_NODE_ORIGIN]  = NODE_ORIGIN_RST;
        cfg_regs[REG_BORROW_LIMIT] = BORROW_LIMIT_RST;
        cfg_regs[REG_SKEW_LIMIT]   = SKEW_LIMIT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(REG_NODE_ORIGIN);
        check_reg(REG_BORROW_LIMIT);
        check_reg(REG_SKEW_LIMIT);

        // opening script under reset settings
        for (int i = 0; i < OPENING_ROWS; i++) begin
            typed_stamp = '{status: SCRIPT[i].st, phys: SCRIPT[i].exp_ms,
                            logical: SCRIPT[i].exp_logical,
                            origin: cfg_regs[REG_NODE_ORIGIN]};
            send_event(SCRIPT[i].mode, SCRIPT[i].now_ms, SCRIPT[i].rem_ms,
                       SCRIPT[i].rem_logical, SCRIPT[i].typed, typed_stamp);
        end

        // random phases, each under its own register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            origin = $urandom;
            case (p)
                0: begin borrow = BORROW_LIMIT_RST; skew = SKEW_LIMIT_RST; end
                1: begin origin = '1; borrow = '0; skew = '0; end
                2: begin borrow = 32'd1; skew = 32'd1; end
                3: begin origin = '0; borrow = '1; skew = '1; end
                4: begin borrow = 32'd20; skew = 32'd500; end
                5: begin borrow = $urandom_range(1, 300); skew = $urandom_range(1, 3000); end
                6: begin borrow = '0; skew = 32'd100; end
                default: begin borrow = 32'd3; skew = '0; end
            endcase
            program_reg({REG_NODE_ORIGIN, 2'b00}, origin);
            program_reg({REG_BORROW_LIMIT, 2'b00}, borrow);
            program_reg({REG_SKEW_LIMIT, 2'b00}, skew);
            if (p == 2 || p == 5)
                program_reg(UNMAPPED_ADDR, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady_flow <= (n >= 60 && n < 100);
                send_random();
            end
        end

        // closing script at the physical ceiling, known settings
        drain_results();
        program_reg({REG_NODE_ORIGIN, 2'b00}, '1);
        program_reg({REG_BORROW_LIMIT, 2'b00}, BORROW_LIMIT_RST);
        program_reg({REG_SKEW_LIMIT, 2'b00}, SKEW_LIMIT_RST);
        for (int i = OPENING_ROWS; i < SCRIPT_ROWS; i++) begin
            typed_stamp = '{status: SCRIPT[i].st, phys: SCRIPT[i].exp_ms,
                            logical: SCRIPT[i].exp_logical,
                            origin: cfg_regs[REG_NODE_ORIGIN]};
            send_event(SCRIPT[i].mode, SCRIPT[i].now_ms, SCRIPT[i].rem_ms,
                       SCRIPT[i].rem_logical, SCRIPT[i].typed, typed_stamp);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[hybrid_logical_clock] OK");
        end else begin
            $display("[hybrid_logical_clock] ERROR");
        end
        $finish;
    end

endmodule
